// File: rtl/average_precision_accumulator_defines.svh
// assertion macros for the average precision accumulator checker
// no dependencies; included by the checker file
`ifndef AVERAGE_PRECISION_ACCUMULATOR_DEFINES_SVH
`define AVERAGE_PRECISION_ACCUMULATOR_DEFINES_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define APA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("apa check failed");

// next-cycle implication, sampled on the rising clock, off during reset
`define APA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("apa check failed");

`endif

// File: rtl/apa_pkg.sv
// shared constants and controller/datapath interface types for the
// average precision accumulator; no dependencies
package apa_pkg;

    localparam int CNT_W           = 17;
    localparam int SUM_W           = 33;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int MAX_LIST_LENGTH = 65536;
    localparam logic [CNT_W-1:0] TOTAL_RESET = 17'd1;

    typedef struct packed {
        logic item_accept;   // count the entry on the input port
        logic div_start;     // launch the shared divider
        logic div_fin;       // 1: final sum / total, 0: found / rank term
        logic sum_add;       // fold the divider quotient into the sum
        logic out_load;      // capture result and clear the list state
    } t_apa_cmd;

    typedef struct packed {
        logic can_count;     // list is still below the length limit
        logic term_ok;       // counting the entry gives a nonzero rank
        logic div_busy;
    } t_apa_sts;

endpackage

// File: rtl/apa_div.sv
// restoring radix-2 divider, one quotient bit per cycle
// depends on apa_pkg for the divisor width
module apa_div #(
    parameter int DIV_W = 33
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [DIV_W-1:0]          i_dividend,
    input  logic [apa_pkg::CNT_W-1:0] i_divisor,
    output logic                      o_busy,
    output logic [DIV_W-1:0]          o_quotient
);
    localparam int CW = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]          r_quo;
    logic [apa_pkg::CNT_W-1:0] r_rem;
    logic [apa_pkg::CNT_W-1:0] r_den;
    logic [CW-1:0]             r_cnt;
    logic                      r_busy;

    logic [apa_pkg::CNT_W:0]   rem_sh;
    logic [apa_pkg::CNT_W:0]   rem_sub;
    logic                      ge;

    always_comb begin
        rem_sh  = {r_rem, r_quo[DIV_W-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        ge      = rem_sh >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(DIV_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-2:0], ge};
            r_rem <= ge ? rem_sub[apa_pkg::CNT_W-1:0] : rem_sh[apa_pkg::CNT_W-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;
endmodule

// File: rtl/apa_datapath.sv
// list counters, precision sum, total register, shared divider and result register
// depends on apa_pkg and apa_div
module apa_datapath #(
    parameter int FRAC_BITS = apa_pkg::FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  apa_pkg::t_apa_cmd         i_cmd,
    output apa_pkg::t_apa_sts         o_sts,
    input  logic                      i_rel,
    input  logic                      i_cfg_wr,
    input  logic [apa_pkg::CNT_W-1:0] i_cfg_data,
    output logic [apa_pkg::CNT_W-1:0] o_avg,
    output logic [apa_pkg::CNT_W-1:0] o_found,
    output logic [apa_pkg::CNT_W-1:0] o_length,
    output logic                      o_sat
);
    localparam int CW    = apa_pkg::CNT_W;
    localparam int SW    = apa_pkg::SUM_W;
    localparam int DIV_W = (SW > CW + FRAC_BITS) ? SW : CW + FRAC_BITS;
    localparam logic [DIV_W-1:0] ONE_FIX = DIV_W'(1) << FRAC_BITS;

    logic [CW-1:0] r_total;
    logic [CW-1:0] r_rank;
    logic [CW-1:0] r_found;
    logic [SW-1:0] r_sum;

    logic [DIV_W-1:0] dividend;
    logic [CW-1:0]    divisor;
    logic [DIV_W-1:0] quo;
    logic             div_busy;
    logic [DIV_W:0]   sum_ext;
    logic             over_one;

    always_comb begin
        if (i_cmd.div_fin) begin
            dividend = DIV_W'(r_sum);
            divisor  = (r_total == '0) ? CW'(1) : r_total;
        end else begin
            dividend = DIV_W'(r_found) << FRAC_BITS;
            divisor  = r_rank;
        end
        sum_ext  = (DIV_W + 1)'(r_sum) + {1'b0, quo};
        over_one = quo > ONE_FIX;
    end

    apa_div #(.DIV_W(DIV_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_busy     (div_busy),
        .o_quotient (quo)
    );

    always_comb begin
        o_sts.can_count = 32'(r_rank) < 32'(apa_pkg::MAX_LIST_LENGTH);
        o_sts.term_ok   = o_sts.can_count && (r_rank != {CW{1'b1}});
        o_sts.div_busy  = div_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= apa_pkg::TOTAL_RESET;
        end else if (i_cfg_wr) begin
            r_total <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank  <= '0;
            r_found <= '0;
            r_sum   <= '0;
        end else if (i_cmd.out_load) begin
            r_rank  <= '0;
            r_found <= '0;
            r_sum   <= '0;
        end else begin
            if (i_cmd.item_accept && o_sts.can_count) begin
                r_rank <= r_rank + 1'b1;
                if (i_rel) begin
                    r_found <= r_found + 1'b1;
                end
            end
            if (i_cmd.sum_add) begin
                // clamp at the full sum width
                if (|sum_ext[DIV_W:SW]) begin
                    r_sum <= {SW{1'b1}};
                end else begin
                    r_sum <= sum_ext[SW-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_avg    <= over_one ? ONE_FIX[CW-1:0] : quo[CW-1:0];
            o_sat    <= over_one;
            o_found  <= r_found;
            o_length <= r_rank;
        end
    end
endmodule

// File: rtl/apa_ctrl.sv
// sequencer for one entry: count, optional term division, final division, output handoff
// depends on apa_pkg
module apa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_rel,
    input  logic              i_last,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output apa_pkg::t_apa_cmd o_cmd,
    input  apa_pkg::t_apa_sts i_sts
);
    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_TERM_START = 3'd1;
    localparam logic [2:0] S_TERM_WAIT  = 3'd2;
    localparam logic [2:0] S_FIN_START  = 3'd3;
    localparam logic [2:0] S_FIN_WAIT   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_last;
    logic       n_last;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       accept;
    logic       out_free;

    always_comb begin
        accept   = i_in_valid && (r_state == S_IDLE);
        out_free = !r_out_valid || i_out_ready;
        n_state  = r_state;
        n_last   = r_last;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.item_accept = 1'b1;
                    n_last            = i_last;
                    if (i_rel && i_sts.term_ok) begin
                        n_state = S_TERM_START;
                    end else if (i_last) begin
                        n_state = S_FIN_START;
                    end
                end
            end
            S_TERM_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_TERM_WAIT;
            end
            S_TERM_WAIT: begin
                if (!i_sts.div_busy) begin
                    o_cmd.sum_add = 1'b1;
                    n_state       = r_last ? S_FIN_START : S_IDLE;
                end
            end
            S_FIN_START: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_fin   = 1'b1;
                n_state         = S_FIN_WAIT;
            end
            S_FIN_WAIT: begin
                o_cmd.div_fin = 1'b1;
                // quotient holds in the divider until the result slot frees up
                if (!i_sts.div_busy && out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
endmodule

// File: rtl/average_precision_accumulator.sv
// channel  | signals                       | word
// ---------+-------------------------------+---------------------------------------------
// s_axis   | tvalid tready tdata tlast     | tdata[0] is_relevant, tlast end_of_list
// m_axis   | tvalid tready tdata tuser     | avg_precision_q16, relevant_found,
//          |                               | list_length in tdata; saturated in tuser
// cfg      | valid ready data              | total_relevant_docs, always ready
//
// a non-relevant entry is only counted; a relevant one adds a found/rank division on the
// shared one-bit-per-cycle divider; the last entry of a list adds the final sum/total
// division
// an item can be taken while the previous result waits in the output register
// a stalled output holds the final quotient in the divider until the register frees
// reset is synchronous, active low; total_relevant_docs resets to 1
module average_precision_accumulator #(
    parameter int FRAC_BITS = apa_pkg::FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [7:0]                i_s_axis_tdata,  // [0] is_relevant, rest zero
    input  logic                      i_s_axis_tlast,
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    // [16:0] avg_precision_q16, [33:17] relevant_found, [50:34] list_length, rest zero
    output logic [55:0]               o_m_axis_tdata,
    output logic                      o_m_axis_tuser,  // [0] saturated
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [apa_pkg::CNT_W-1:0] i_cfg_data
);
    apa_pkg::t_apa_cmd         cmd;
    apa_pkg::t_apa_sts         sts;
    logic [apa_pkg::CNT_W-1:0] avg;
    logic [apa_pkg::CNT_W-1:0] found;
    logic [apa_pkg::CNT_W-1:0] length;
    logic                      sat;

    apa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_rel       (i_s_axis_tdata[0]),
        .i_last      (i_s_axis_tlast),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    apa_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_rel      (i_s_axis_tdata[0]),
        .i_cfg_wr   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_avg      (avg),
        .o_found    (found),
        .o_length   (length),
        .o_sat      (sat)
    );

    assign o_cfg_ready    = 1'b1;
    assign o_m_axis_tdata = {5'd0, length, found, avg};
    assign o_m_axis_tuser = sat;
endmodule

// File: rtl/apa_checker.sv
// port-level checks for the average precision accumulator, bound to the top level
// depends on apa_pkg and average_precision_accumulator_defines.svh
`include "average_precision_accumulator_defines.svh"

module apa_checker #(
    parameter int FRAC_BITS = apa_pkg::FRAC_BITS_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [55:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser
);
    localparam logic [16:0] ONE_OUT = 17'(64'd1 << FRAC_BITS);
    localparam bit NO_WRAP = apa_pkg::MAX_LIST_LENGTH < 131072;

    // a clamped result shows exactly 1.0
    `APA_ASSERT_IMP(a_sat_is_one, o_m_axis_tvalid && o_m_axis_tuser,
        o_m_axis_tdata[16:0] == ONE_OUT)

    // relevant count never exceeds the list length, and a list is never empty
    `APA_ASSERT_IMP(a_found_le_len, o_m_axis_tvalid && NO_WRAP,
        (o_m_axis_tdata[33:17] <= o_m_axis_tdata[50:34]) && (o_m_axis_tdata[50:34] != 17'd0))

    // a stalled result word holds
    `APA_ASSERT_NXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
endmodule

bind average_precision_accumulator apa_checker #(.FRAC_BITS(FRAC_BITS)) u_apa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

// File: tb/sv/average_precision_accumulator_tb.sv
// self-checking testbench for average_precision_accumulator: ranked lists go in on the
// s_axis port, results are checked against an in-bench average precision predictor
// depends on apa_pkg and the average_precision_accumulator rtl
module average_precision_accumulator_tb;

    localparam int FRAC = apa_pkg::FRAC_BITS_DEF;
    localparam int CW   = apa_pkg::CNT_W;
    localparam int SW   = apa_pkg::SUM_W;
    localparam longint unsigned SUM_CEIL = (64'd1 << apa_pkg::SUM_W) - 64'd1;
    localparam longint unsigned ONE_Q    = 64'd1 << FRAC;
    localparam int PHASE_ITEMS = 270;
    localparam int DRAIN_GAP   = 100;

    typedef struct packed {
        logic rel;
        logic last;
    } t_entry;

    typedef struct packed {
        logic [CW-1:0] avg;
        logic [CW-1:0] found;
        logic [CW-1:0] len;
        logic          sat;
    } t_ap_result;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_tvalid = 1'b0;
    logic [7:0]    s_tdata = 8'd0;
    logic          s_tlast = 1'b0;
    logic          m_tready = 1'b0;
    logic          cfg_valid = 1'b0;
    logic [CW-1:0] cfg_data = '0;
    logic          o_s_axis_tready;
    logic          o_m_axis_tvalid;
    logic [55:0]   o_m_axis_tdata;
    logic          o_m_axis_tuser;
    logic          o_cfg_ready;

    t_entry     entry_queue[$];
    t_ap_result ap_expected[$];

    // predictor state
    logic [CW-1:0]             ap_total = apa_pkg::TOTAL_RESET;
    logic [CW-1:0]             ap_rank = '0;
    logic [CW-1:0]             ap_found = '0;
    logic [apa_pkg::SUM_W-1:0] ap_sum = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int err_count = 0;
    int results_seen = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    average_precision_accumulator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tlast (s_tlast),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // fold one accepted entry into the running sum; a last entry yields the result
    function automatic void ap_fold_entry(input logic rel, input logic last);
        longint unsigned fnd, rnk, acc, div, q;
        t_ap_result r;
        if (ap_rank < apa_pkg::MAX_LIST_LENGTH) begin
            ap_rank = ap_rank + 1'b1;
            if (rel) begin
                ap_found = ap_found + 1'b1;
                fnd = 64'(ap_found);
                rnk = 64'(ap_rank);
                acc = 64'(ap_sum);
                acc = acc + (fnd << FRAC) / rnk;
                ap_sum = SW'((acc > SUM_CEIL) ? SUM_CEIL : acc);
            end
        end
        if (last) begin
            div = (ap_total == '0) ? 64'd1 : 64'(ap_total);
            acc = 64'(ap_sum);
            q = acc / div;
            r.sat = (q > ONE_Q);
            r.avg = CW'(r.sat ? ONE_Q : q);
            r.found = ap_found;
            r.len = ap_rank;
            ap_expected.push_back(r);
            ap_rank = '0;
            ap_found = '0;
            ap_sum = '0;
        end
    endfunction

    // sender
    always @(posedge i_clk) begin : drv
        t_entry e;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_axis_tready) begin
                ap_fold_entry(s_tdata[0], s_tlast);
            end
            if (!s_tvalid || o_s_axis_tready) begin
                if (entry_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    e = entry_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {7'd0, e.rel};
                    s_tlast <= e.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver, with one long hold-off so the block backs up into its input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen >= 60) begin
            m_tready <= 1'b0;
            hold_left <= 1500;
            hold_done <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin : mon
        t_ap_result r;
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            results_seen <= results_seen + 1;
            if (ap_expected.size() == 0) begin
                $error("result word with no expectation pending");
                err_count++;
            end else begin
                r = ap_expected.pop_front();
                if (o_m_axis_tdata[16:0] !== r.avg) begin
                    $error("avg_precision_q16: expected %0d, got %0d",
                           r.avg, o_m_axis_tdata[16:0]);
                    err_count++;
                end
                if (o_m_axis_tdata[33:17] !== r.found) begin
                    $error("relevant_found: expected %0d, got %0d",
                           r.found, o_m_axis_tdata[33:17]);
                    err_count++;
                end
                if (o_m_axis_tdata[50:34] !== r.len) begin
                    $error("list_length: expected %0d, got %0d",
                           r.len, o_m_axis_tdata[50:34]);
                    err_count++;
                end
                if (o_m_axis_tuser !== r.sat) begin
                    $error("saturated: expected %0d, got %0d", r.sat, o_m_axis_tuser);
                    err_count++;
                end
            end
        end
    end

    // bit i of pat is the relevance of entry i
    task automatic add_bits(input int len, input logic [31:0] pat);
        for (int i = 0; i < len; i++) begin
            entry_queue.push_back('{rel: pat[i], last: (i == len - 1)});
        end
    endtask

    task automatic add_list(input int len, input int rel_pct);
        for (int i = 0; i < len; i++) begin
            entry_queue.push_back('{rel: ($urandom_range(99) < rel_pct),
                                    last: (i == len - 1)});
        end
    endtask

    task automatic wait_drained();
        while (entry_queue.size() > 0 || s_tvalid || ap_expected.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    task automatic write_total(input logic [CW-1:0] v);
        wait_drained();
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        ap_total = v;
    endtask

    task automatic random_phase(input int items);
        int added;
        int len;
        added = 0;
        while (added < items) begin
            len = ($urandom_range(19) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 30);
            add_list(len, $urandom_range(100));
            added += len;
        end
    endtask

    initial begin
        logic [CW-1:0] totals[6];
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 34;
        recv_idle_pct = 47;

        // reset divisor of one: empty-relevance list, exact 1.0, clamp above 1.0,
        // fractional terms with truncation
        add_bits(1, 32'b0);
        add_bits(1, 32'b1);
        add_bits(2, 32'b11);
        add_bits(4, 32'b1010);
        add_bits(3, 32'b100);
        // zero divisor acts as one
        write_total('0);
        add_bits(3, 32'b111);
        write_total(17'd3);
        add_bits(4, 32'b1101);
        write_total(17'd131071);
        add_bits(2, 32'b11);
        write_total(17'd65536);
        add_bits(1, 32'b1);

        totals[0] = 17'd1;
        totals[1] = CW'($urandom_range(2, 8));
        totals[2] = CW'($urandom_range(9, 60));
        totals[3] = 17'd131071;
        totals[4] = CW'($urandom_range(1, 131071));
        totals[5] = CW'($urandom_range(1, 5));
        for (int ph = 0; ph < 6; ph++) begin
            write_total(totals[ph]);
            if (ph == 2) begin
                send_idle_pct = 47;
                recv_idle_pct = 34;
            end else if (ph == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_phase(PHASE_ITEMS);
        end

        wait_drained();
        if (err_count == 0) begin
            $display("average_precision_accumulator regression: pass");
        end else begin
            $display("average_precision_accumulator regression: fail");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("average_precision_accumulator regression: fail");
        $finish;
    end

endmodule

// File: average_precision_accumulator.f
+incdir+rtl
rtl/apa_pkg.sv
rtl/apa_div.sv
rtl/apa_datapath.sv
rtl/apa_ctrl.sv
rtl/average_precision_accumulator.sv
rtl/apa_checker.sv
tb/sv/average_precision_accumulator_tb.sv
